// ----- rtl/strsplit_pkg.sv -----
// shared types and constants of the string separator splitter
package strsplit_pkg;

  localparam int unsigned SEP_LIMIT   = 8;
  localparam int unsigned MAX_SEP_DEF = 8;
  localparam int unsigned NB_W        = $clog2(SEP_LIMIT + 1);
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned SEPB_W      = 64;
  localparam int unsigned TOT_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES  = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [NB_W-1:0]  nbytes;
    logic             first;
    logic             close;
    logic             done;
    logic [TOT_W-1:0] total;
  } plan_ctl_t;

endpackage

// ----- rtl/strsplit_in_if.sv -----
// input byte channel
interface strsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- rtl/strsplit_res_if.sv -----
// result channel
interface strsplit_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  token_byte;
  logic        token_first;
  logic [15:0] token_total;
  logic        run_last;

  modport source (output valid, output kind, output token_byte, output token_first,
                  output token_total, output run_last, input ready);
  modport sink (input valid, input kind, input token_byte, input token_first,
                input token_total, input run_last, output ready);
endinterface

// ----- rtl/string_separator_splitter_top.sv -----
// top level of the string separator splitter
// Takes one string byte per request and splits the string at a configured separator of up
// to MAX_SEP bytes. A byte that yields zero or one result is accepted every cycle unless the
// output stalls. A byte that releases r results (held bytes, token end, string done; r is at
// most MAX_SEP + 1) keeps the next byte waiting until its last result has left, since results
// leave one per cycle through the single output register while the output does not stall,
// and the next byte waits on the plan register. The first result of a byte passes through
// the plan register and then the output register.
module string_separator_splitter_top #(
  parameter int unsigned MAX_SEP = strsplit_pkg::MAX_SEP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [strsplit_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [strsplit_pkg::SEPB_W-1:0]     cfg_wdata_i,
  strsplit_in_if.sink                         in_i,
  strsplit_res_if.source                      res_o
);

  logic [strsplit_pkg::LEN_W-1:0]   sep_length_q;
  logic [strsplit_pkg::SEPB_W-1:0]  sep_bytes_q;
  logic                             take, rdy, plan_vld;
  strsplit_pkg::plan_ctl_t          plan_ctl;
  logic [MAX_SEP-1:0][7:0]          plan_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_length_q <= '0;
      sep_bytes_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        strsplit_pkg::REG_SEP_LENGTH: sep_length_q <= cfg_wdata_i[strsplit_pkg::LEN_W-1:0];
        strsplit_pkg::REG_SEP_BYTES:  sep_bytes_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = rdy;
  assign take       = in_i.valid && rdy;

  strsplit_plan #(
    .MAX_SEP (MAX_SEP)
  ) u_plan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .in_byte_i    (in_i.in_byte),
    .sep_length_i (sep_length_q),
    .sep_bytes_i  (sep_bytes_q),
    .plan_vld_o   (plan_vld),
    .plan_ctl_o   (plan_ctl),
    .plan_bytes_o (plan_bytes)
  );

  strsplit_drain #(
    .MAX_SEP (MAX_SEP)
  ) u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .plan_vld_i   (plan_vld),
    .plan_ctl_i   (plan_ctl),
    .plan_bytes_i (plan_bytes),
    .ready_o      (rdy),
    .res_o        (res_o)
  );

endmodule

// ----- rtl/strsplit_plan.sv -----
// separator match state and per-byte result plan
module strsplit_plan #(
  parameter int unsigned MAX_SEP = strsplit_pkg::MAX_SEP_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic [7:0]                       in_byte_i,
  input  logic [strsplit_pkg::LEN_W-1:0]   sep_length_i,
  input  logic [strsplit_pkg::SEPB_W-1:0]  sep_bytes_i,
  output logic                             plan_vld_o,
  output strsplit_pkg::plan_ctl_t          plan_ctl_o,
  output logic [MAX_SEP-1:0][7:0]          plan_bytes_o
);

  localparam int unsigned CW = $clog2(MAX_SEP + 1);

  logic [MAX_SEP-1:0][7:0]           held_q, held_d;
  logic [CW-1:0]                     hcnt_q, hcnt_d;
  logic                              open_q, open_d;
  logic [strsplit_pkg::TOT_W-1:0]    tcnt_q, tcnt_d, tcnt_inc;
  logic [CW-1:0]                     len, n, k, suf;
  logic [MAX_SEP-1:0][7:0]           b;
  logic [MAX_SEP-1:0]                mt;
  logic                              hit, full, close_e;
  logic [8*MAX_SEP-1:0]              rest;
  strsplit_pkg::plan_ctl_t           ctl;

  // clamp separator length
  always_comb begin
    if (sep_length_i > strsplit_pkg::LEN_W'(MAX_SEP)) begin
      len = CW'(MAX_SEP);
    end else begin
      len = sep_length_i[CW-1:0];
    end
  end

  // held bytes followed by the new byte
  assign n = hcnt_q + CW'(1);

  always_comb begin
    for (int j = 0; j < int'(MAX_SEP); j++) begin
      if (CW'(j) < hcnt_q) begin
        b[j] = held_q[j];
      end else if (CW'(j) == hcnt_q) begin
        b[j] = in_byte_i;
      end else begin
        b[j] = 8'h00;
      end
    end
  end

  // suffix starting at k is a separator prefix
  always_comb begin
    for (int kk = 0; kk < int'(MAX_SEP); kk++) begin
      mt[kk] = (CW'(kk) < n) && (len != '0) && ((n - CW'(kk)) <= len);
      for (int j = 0; j < int'(MAX_SEP) - kk; j++) begin
        if ((CW'(j) < (n - CW'(kk))) && (b[kk+j] != sep_bytes_i[8*j +: 8])) begin
          mt[kk] = 1'b0;
        end
      end
    end
  end

  // leftmost matching suffix
  always_comb begin
    hit = 1'b0;
    k   = n;
    for (int i = int'(MAX_SEP) - 1; i >= 0; i--) begin
      if (mt[i]) begin
        hit = 1'b1;
        k   = CW'(i);
      end
    end
  end

  assign suf      = n - k;
  assign full     = hit && (suf == len);
  assign rest     = b >> {k, 3'b000};
  assign tcnt_inc = (tcnt_q == '1) ? tcnt_q : tcnt_q + strsplit_pkg::TOT_W'(1);

  always_comb begin
    held_d = held_q;
    hcnt_d = hcnt_q;
    open_d = open_q;
    tcnt_d = tcnt_q;
    if (in_byte_i == 8'h00) begin
      close_e    = open_q || (hcnt_q != '0);
      ctl.nbytes = strsplit_pkg::NB_W'(hcnt_q);
      ctl.first  = !open_q;
      ctl.close  = close_e;
      ctl.done   = 1'b1;
      ctl.total  = close_e ? tcnt_inc : tcnt_q;
      held_d     = '0;
      hcnt_d     = '0;
      open_d     = 1'b0;
      tcnt_d     = '0;
    end else begin
      close_e    = full && (open_q || (k != '0));
      ctl.nbytes = strsplit_pkg::NB_W'(k);
      ctl.first  = !open_q;
      ctl.close  = close_e;
      ctl.done   = 1'b0;
      ctl.total  = '0;
      held_d     = (hit && !full) ? rest : '0;
      hcnt_d     = (hit && !full) ? suf : '0;
      open_d     = full ? 1'b0 : (open_q || (k != '0));
      tcnt_d     = close_e ? tcnt_inc : tcnt_q;
    end
  end

  assign plan_ctl_o   = ctl;
  assign plan_bytes_o = b;
  assign plan_vld_o   = (ctl.nbytes != '0) || ctl.close || ctl.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      hcnt_q <= '0;
      open_q <= 1'b0;
      tcnt_q <= '0;
    end else if (take_i) begin
      held_q <= held_d;
      hcnt_q <= hcnt_d;
      open_q <= open_d;
      tcnt_q <= tcnt_d;
    end
  end

  a_held_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q < CW'(MAX_SEP))
    else $error("held byte count reached separator limit");

  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && (in_byte_i == 8'h00) |=> (hcnt_q == '0) && !open_q && (tcnt_q == '0))
    else $error("string state not cleared after terminator");

endmodule

// ----- rtl/strsplit_drain.sv -----
// plan register and result output register
module strsplit_drain #(
  parameter int unsigned MAX_SEP = strsplit_pkg::MAX_SEP_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic                      plan_vld_i,
  input  strsplit_pkg::plan_ctl_t   plan_ctl_i,
  input  logic [MAX_SEP-1:0][7:0]   plan_bytes_i,
  output logic                      ready_o,
  strsplit_res_if.source            res_o
);

  localparam int unsigned RW = $clog2(MAX_SEP + 3);
  localparam int unsigned IW = (MAX_SEP > 1) ? $clog2(MAX_SEP) : 1;

  logic                            pv_q;
  strsplit_pkg::plan_ctl_t         pc_q;
  logic [MAX_SEP-1:0][7:0]         pb_q;
  logic [RW-1:0]                   pos_q, nres;
  logic                            last, advance;
  strsplit_pkg::kind_e             kind;
  logic [7:0]                      tbyte;
  logic                            tfirst;
  logic [strsplit_pkg::TOT_W-1:0]  ttotal;

  logic                            ov_q;
  strsplit_pkg::kind_e             kind_q;
  logic [7:0]                      tbyte_q;
  logic                            tfirst_q;
  logic [strsplit_pkg::TOT_W-1:0]  ttotal_q;
  logic                            last_q;

  assign nres    = RW'(pc_q.nbytes) + RW'(pc_q.close) + RW'(pc_q.done);
  assign last    = (pos_q == nres - RW'(1));
  assign advance = pv_q && (!ov_q || res_o.ready);
  assign ready_o = !pv_q || (advance && last);

  always_comb begin
    kind   = strsplit_pkg::KIND_DONE;
    tbyte  = 8'h00;
    tfirst = 1'b0;
    ttotal = '0;
    if (RW'(pc_q.nbytes) > pos_q) begin
      kind   = strsplit_pkg::KIND_BYTE;
      tbyte  = pb_q[pos_q[IW-1:0]];
      tfirst = pc_q.first && (pos_q == '0);
    end else if (pc_q.close && (pos_q == RW'(pc_q.nbytes))) begin
      kind = strsplit_pkg::KIND_END;
    end else begin
      ttotal = pc_q.total;
    end
  end

  // pending request plan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      pc_q  <= '0;
      pb_q  <= '0;
      pos_q <= '0;
    end else if (take_i) begin
      pv_q  <= plan_vld_i;
      pc_q  <= plan_ctl_i;
      pb_q  <= plan_bytes_i;
      pos_q <= '0;
    end else if (advance) begin
      if (last) begin
        pv_q <= 1'b0;
      end else begin
        pos_q <= pos_q + RW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      kind_q   <= strsplit_pkg::KIND_BYTE;
      tbyte_q  <= 8'h00;
      tfirst_q <= 1'b0;
      ttotal_q <= '0;
      last_q   <= 1'b0;
    end else if (advance) begin
      ov_q     <= 1'b1;
      kind_q   <= kind;
      tbyte_q  <= tbyte;
      tfirst_q <= tfirst;
      ttotal_q <= ttotal;
      last_q   <= last;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.kind        = kind_q;
  assign res_o.token_byte  = tbyte_q;
  assign res_o.token_first = tfirst_q;
  assign res_o.token_total = ttotal_q;
  assign res_o.run_last    = last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (pos_q < nres))
    else $error("plan position past result count");

  a_plan_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q && !advance |=> pv_q && $stable(pos_q))
    else $error("stalled plan lost");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (kind_q == strsplit_pkg::KIND_DONE) |-> last_q)
    else $error("string done is not the last result");

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the string separator splitter
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct packed {
    strsplit_pkg::kind_e            kind;
    logic [7:0]                     tbyte;
    logic                           first;
    logic [strsplit_pkg::TOT_W-1:0] total;
    logic                           last;
  } split_res_t;

  logic                               clk;
  logic                               rst_ni;
  logic                               cfg_we;
  logic [strsplit_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [strsplit_pkg::SEPB_W-1:0]    cfg_wdata;

  strsplit_in_if  in_if ();
  strsplit_res_if res_if ();

  string_separator_splitter_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  // splitter state mirrored by the predictor
  logic [strsplit_pkg::LEN_W-1:0]  sep_len_q;
  logic [strsplit_pkg::SEPB_W-1:0] sep_bytes_q;
  logic [7:0]                      held_q [7];
  int unsigned                     held_cnt;
  bit                              tok_open;
  logic [strsplit_pkg::TOT_W-1:0]  tok_count;

  split_res_t  expected_q [$];
  split_res_t  step_res [$];
  split_res_t  exp_head;

  int          err_cnt = 0;
  int          src_idle;
  int          snk_idle;
  int          idle_cycles = 0;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned results_seen = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void emit_tok_byte(input logic [7:0] b);
    split_res_t r;
    r = '0;
    r.kind  = strsplit_pkg::KIND_BYTE;
    r.tbyte = b;
    r.first = !tok_open;
    step_res = {step_res, r};
    tok_open = 1'b1;
  endfunction

  function automatic void close_tok();
    split_res_t r;
    r = '0;
    if (tok_open) begin
      r.kind = strsplit_pkg::KIND_END;
      step_res = {step_res, r};
      if (tok_count != 16'hFFFF) tok_count++;
      tok_open = 1'b0;
    end
  endfunction

  function automatic void predict_split(input logic [7:0] c);
    split_res_t  r;
    logic [7:0]  win [8];
    int unsigned n;
    int unsigned eff_len;
    bit          pfx;
    eff_len = (sep_len_q > strsplit_pkg::MAX_SEP_DEF) ? strsplit_pkg::MAX_SEP_DEF : sep_len_q;
    n = held_cnt;
    step_res.delete();
    if (c == 8'd0) begin
      for (int i = 0; i < n; i++) emit_tok_byte(held_q[i]);
      close_tok();
      r = '0;
      r.kind  = strsplit_pkg::KIND_DONE;
      r.total = tok_count;
      step_res = {step_res, r};
      for (int i = 0; i < 7; i++) held_q[i] = 8'd0;
      held_cnt  = 0;
      tok_open  = 1'b0;
      tok_count = '0;
      strings_sent++;
    end else begin
      for (int i = 0; i < 7; i++) win[i] = held_q[i];
      win[7] = 8'd0;
      win[n] = c;
      n++;
      while (n > 0) begin
        pfx = (eff_len > 0) && (n <= eff_len);
        for (int i = 0; i < n; i++)
          if (pfx && win[i] != sep_bytes_q[8*i +: 8]) pfx = 1'b0;
        if (pfx) begin
          if (n == eff_len) begin
            close_tok();
            n = 0;
          end
          break;
        end
        emit_tok_byte(win[0]);
        for (int i = 0; i < 7; i++) win[i] = win[i+1];
        n--;
      end
      for (int i = 0; i < 7; i++) held_q[i] = (i < n) ? win[i] : 8'd0;
      held_cnt = n;
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      expected_q = {expected_q, r};
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h", res_if.kind, res_if.token_byte);
        err_cnt++;
      end else begin
        exp_head = expected_q.pop_front();
        results_seen++;
        if (res_if.kind !== exp_head.kind) begin
          $error("kind: expected %0d, actual %0d", exp_head.kind, res_if.kind);
          err_cnt++;
        end
        if (res_if.token_byte !== exp_head.tbyte) begin
          $error("token_byte: expected %0h, actual %0h", exp_head.tbyte, res_if.token_byte);
          err_cnt++;
        end
        if (res_if.token_first !== exp_head.first) begin
          $error("token_first: expected %0d, actual %0d", exp_head.first, res_if.token_first);
          err_cnt++;
        end
        if (res_if.token_total !== exp_head.total) begin
          $error("token_total: expected %0d, actual %0d", exp_head.total, res_if.token_total);
          err_cnt++;
        end
        if (res_if.run_last !== exp_head.last) begin
          $error("run_last: expected %0d, actual %0d", exp_head.last, res_if.run_last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on stalled handshakes
  always @(posedge clk) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_ni)
      res_if.ready <= 1'b0;
    else
      res_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_split(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [strsplit_pkg::CFG_IDX_W-1:0] idx,
                           input logic [strsplit_pkg::SEPB_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == strsplit_pkg::REG_SEP_LENGTH) sep_len_q = data[strsplit_pkg::LEN_W-1:0];
    else sep_bytes_q = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sep(input logic [strsplit_pkg::LEN_W-1:0] len,
                         input logic [strsplit_pkg::SEPB_W-1:0] seps);
    logic [strsplit_pkg::SEPB_W-1:0] lw;
    lw = {$urandom, $urandom};
    lw[strsplit_pkg::LEN_W-1:0] = len;
    wait_drained();
    write_reg(strsplit_pkg::REG_SEP_LENGTH, lw);
    write_reg(strsplit_pkg::REG_SEP_BYTES, seps);
  endtask

  task automatic set_random_sep();
    int                              sel;
    int                              mode;
    logic [strsplit_pkg::LEN_W-1:0]  len;
    logic [strsplit_pkg::SEPB_W-1:0] seps;
    sel = $urandom_range(9);
    if (sel == 0) len = '0;
    else if (sel == 1) len = strsplit_pkg::LEN_W'(1);
    else if (sel == 2) len = strsplit_pkg::LEN_W'(8);
    else if (sel == 3) len = strsplit_pkg::LEN_W'($urandom_range(15, 9));
    else len = strsplit_pkg::LEN_W'($urandom_range(7, 2));
    mode = $urandom_range(9);
    for (int i = 0; i < 8; i++) begin
      if (mode <= 5) seps[8*i +: 8] = 8'($urandom_range(255, 1));
      else if (mode <= 7) seps[8*i +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
      else if (mode == 8) seps[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h01;
      else seps[8*i +: 8] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
    end
    set_sep(len, seps);
  endtask

  function automatic logic [7:0] sep_byte_at(input int i);
    logic [7:0] b;
    b = sep_bytes_q[8*(i % 8) +: 8];
    return (b == 8'd0) ? 8'd1 : b;
  endfunction

  task automatic send_text(input string s, input bit term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    if (term) send_byte(8'd0);
  endtask

  task automatic send_random_string();
    int pieces;
    int sel;
    int eff;
    int cnt;
    if ($urandom_range(9) == 0) begin
      // noise
      repeat ($urandom_range(12)) send_byte(8'($urandom_range(255, 1)));
    end else begin
      pieces = $urandom_range(6);
      repeat (pieces) begin
        eff = (sep_len_q > strsplit_pkg::MAX_SEP_DEF) ? strsplit_pkg::MAX_SEP_DEF : sep_len_q;
        if (eff == 0) eff = 1;
        sel = $urandom_range(9);
        if (sel <= 3) begin
          for (int i = 0; i < eff; i++) send_byte(sep_byte_at(i));
        end else if (sel <= 5) begin
          cnt = (eff > 1) ? $urandom_range(eff - 1, 1) : 1;
          for (int i = 0; i < cnt; i++) send_byte(sep_byte_at(i));
        end else begin
          repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(1)) send_byte(sep_byte_at($urandom_range(7)));
            else send_byte(8'($urandom_range(255, 1)));
          end
        end
        if ($urandom_range(19) == 0) set_random_sep();
      end
    end
    send_byte(8'd0);
  endtask

  task automatic test_directed();
    // no separator: whole string is one token, then an empty string
    send_text("a\377", 1'b1);
    send_text("", 1'b1);
    // two-byte separator with empty tokens, partial match and held bytes at the end
    set_sep(4'd2, 64'h3b2c);
    send_text(",;\001,,;b,", 1'b1);
    // separator changed while a byte is held
    set_sep(4'd2, 64'h6261);
    send_text("xa", 1'b0);
    set_sep(4'd0, 64'h6261);
    send_text("y", 1'b1);
    // oversized length, held bytes flushed by the terminator
    set_sep(4'd15, 64'h2d2d2d2d2d2d2d2d);
    send_text("---", 1'b1);
    // zero separator byte never matches
    set_sep(4'd1, 64'h0);
    send_text("z", 1'b1);
  endtask

  task automatic test_random(input int unsigned target);
    int unsigned start;
    start = bytes_sent;
    set_random_sep();
    while (bytes_sent - start < target) begin
      if ($urandom_range(5) == 0) set_random_sep();
      send_random_string();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'd0;
    sep_len_q     = '0;
    sep_bytes_q   = '0;
    for (int i = 0; i < 7; i++) held_q[i] = 8'd0;
    held_cnt      = 0;
    tok_open      = 1'b0;
    tok_count     = '0;
    bytes_sent    = 0;
    strings_sent  = 0;
    src_idle      = 12;
    snk_idle      = 83;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(110);
    src_idle = 83;
    snk_idle = 12;
    test_random(110);
    src_idle = 0;
    snk_idle = 0;
    test_random(110);
    wait_drained();

    $display("%0d bytes in %0d strings sent, %0d results checked, %0d mismatches",
             bytes_sent, strings_sent, results_seen, err_cnt);
    $display("covered separator lengths 0 to 15, mid-string changes and empty tokens");
    if (err_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
